// ===== hdl/ctt_pkg.sv =====
// Shared types, sizes and codes of the countdown timer table.
package ctt_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SLOT_W    = 6;
   localparam int COUNT_W   = 16;
   localparam int TAG_W     = 16;
   localparam int KIND_W    = 2;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_ARM  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ARMED   = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_EXPIRED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARM_SCAN,
      ST_TICK_READ,
      ST_TICK_UPDATE
   } ctt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic idx_inc;
      logic arm_write;
      logic arm_result;
      logic full_result;
      logic mem_read;
      logic tick_emit;
      logic tick_dec;
   } ctt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cur_valid;
      logic cur_expiring;
      logic idx_last;
      logic out_free;
   } ctt_sts_type;

endpackage

// ===== hdl/ctt_req_if.sv =====
// Input item channel of the countdown timer table.
interface ctt_req_if import ctt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [COUNT_W-1:0] count;
   logic [TAG_W-1:0]   tag;

   modport source (output valid, output mode, output count, output tag, input ready);
   modport sink   (input valid, input mode, input count, input tag, output ready);
endinterface

// ===== hdl/ctt_rsp_if.sv =====
// Result item channel of the countdown timer table.
interface ctt_rsp_if import ctt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] slot;
   logic [TAG_W-1:0]  tag_out;
   logic              last;

   modport source (output valid, output kind, output slot, output tag_out, output last,
                   input ready);
   modport sink   (input valid, input kind, input slot, input tag_out, input last,
                   output ready);
endinterface

// ===== hdl/countdown_timer_table_unit.sv =====
// Top level of the countdown timer table: controller and datapath joined by command and status.
//
// The block keeps NUM_SLOTS countdown timers. An arm item (mode 1) claims the lowest free
// slot, stores its count and tag, and answers with one item of kind armed carrying the slot;
// when every slot is busy it answers with one item of kind full. A tick item (mode 0) walks
// the slots in ascending order: each armed timer counts down, and every timer that reaches
// zero (a timer armed with zero included) is freed and reported by an item of kind expired
// carrying its slot and tag, the final one of the tick marked last. A tick that frees nothing
// gives no item. One item is worked on at a time. The arm scan looks at the slots one by
// one from the lowest until it finds a free slot or reaches the last one. The tick walk
// passes over each free slot and takes two steps for each armed slot: a registered read of
// the count and tag memories, then the update. A result sits in an output register, so the
// block goes back to accepting items while it waits to be taken; the scan or walk only
// pauses when a new result meets an output register that is still full.
module countdown_timer_table_unit import ctt_pkg::*; (
   input logic       clock,
   input logic       reset,
   ctt_req_if.sink   req_ch,
   ctt_rsp_if.source rsp_ch
);

   ctt_cmd_type cmd;
   ctt_sts_type sts;

   // Sequencer: decides when an item is taken and steps the slot walk.
   ctt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Slot flags, count and tag memories, and the result register.
   ctt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_mode  (req_ch.mode),
      .req_count (req_ch.count),
      .req_tag   (req_ch.tag),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== hdl/ctt_ctrl.sv =====
// Controller state machine of the countdown timer table.
module ctt_ctrl import ctt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_mode,
   output logic        req_ready,
   input  ctt_sts_type sts,
   output ctt_cmd_type cmd
);

   ctt_state_type state_ff;
   ctt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_mode == MODE_ARM) ? ST_ARM_SCAN : ST_TICK_READ;
            end
         end
         ST_ARM_SCAN: begin
            if (!sts.cur_valid) begin
               if (sts.out_free) begin
                  cmd.arm_write  = 1'b1;
                  cmd.arm_result = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (sts.idx_last) begin
               if (sts.out_free) begin
                  cmd.full_result = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_TICK_READ: begin
            if (sts.cur_valid) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_TICK_UPDATE;
            end else if (sts.idx_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_TICK_UPDATE: begin
            if (!sts.cur_expiring || sts.out_free) begin
               cmd.tick_emit = sts.cur_expiring;
               cmd.tick_dec  = !sts.cur_expiring;
               if (sts.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_TICK_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/ctt_dpath.sv =====
// Datapath of the countdown timer table: slot flags, count and tag memories, result register.
module ctt_dpath import ctt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctt_cmd_type        cmd,
   output ctt_sts_type        sts,
   input  logic               req_mode,
   input  logic [COUNT_W-1:0] req_count,
   input  logic [TAG_W-1:0]   req_tag,
   ctt_rsp_if.source          rsp_ch
);

   logic [COUNT_W-1:0] count_mem [NUM_SLOTS];
   logic [TAG_W-1:0]   tag_mem   [NUM_SLOTS];

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] le1_ff, le1_in;
   logic [NUM_SLOTS-1:0] expmask_ff, expmask_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 item_mode_ff, item_mode_in;
   logic [COUNT_W-1:0]   item_count_ff, item_count_in;
   logic [TAG_W-1:0]     item_tag_ff, item_tag_in;
   logic [COUNT_W-1:0]   rd_count_ff;
   logic [TAG_W-1:0]     rd_tag_ff;

   logic                 out_valid_ff, out_valid_in;
   kind_type             out_kind_ff, out_kind_in;
   logic [SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic [TAG_W-1:0]     out_tag_ff, out_tag_in;
   logic                 out_last_ff, out_last_in;

   logic [NUM_SLOTS-1:0] slot_onehot;
   logic                 load;

   assign sts.cur_valid    = valid_ff[idx_ff];
   assign sts.cur_expiring = le1_ff[idx_ff];
   assign sts.idx_last     = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign sts.out_free     = !out_valid_ff || rsp_ch.ready;

   assign load = cmd.arm_result || cmd.full_result || cmd.tick_emit;

   always_comb begin
      slot_onehot         = '0;
      slot_onehot[idx_ff] = 1'b1;

      valid_in      = valid_ff;
      le1_in        = le1_ff;
      expmask_in    = expmask_ff;
      idx_in        = idx_ff;
      item_mode_in  = item_mode_ff;
      item_count_in = item_count_ff;
      item_tag_in   = item_tag_ff;

      if (cmd.accept) begin
         item_mode_in  = req_mode;
         item_count_in = req_count;
         item_tag_in   = req_tag;
         idx_in        = '0;
         // Snapshot of the slots that expire on this tick; it tells which result is last.
         expmask_in    = valid_ff & le1_ff;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.arm_write) begin
         valid_in = valid_ff | slot_onehot;
         le1_in[idx_ff] = (item_count_ff <= COUNT_W'(1));
      end
      if (cmd.tick_emit) begin
         valid_in   = valid_ff & ~slot_onehot;
         expmask_in = expmask_ff & ~slot_onehot;
      end
      if (cmd.tick_dec) begin
         le1_in[idx_ff] = (rd_count_ff == COUNT_W'(2));
      end

      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_kind_in  = out_kind_ff;
      out_slot_in  = out_slot_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b1;
         out_tag_in   = '0;
         out_slot_in  = SLOT_W'(idx_ff);
         out_kind_in  = KIND_ARMED;
         if (cmd.full_result) begin
            out_kind_in = KIND_FULL;
            out_slot_in = '0;
         end else if (cmd.tick_emit) begin
            out_kind_in = KIND_EXPIRED;
            out_tag_in  = rd_tag_ff;
            out_last_in = ~|(expmask_ff & ~slot_onehot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         le1_ff       <= '0;
         expmask_ff   <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         le1_ff       <= le1_in;
         expmask_ff   <= expmask_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_count_ff <= item_count_in;
      item_tag_ff   <= item_tag_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   // Count and tag memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.arm_write) begin
         count_mem[idx_ff] <= item_count_ff;
         tag_mem[idx_ff]   <= item_tag_ff;
      end else if (cmd.tick_dec) begin
         count_mem[idx_ff] <= rd_count_ff - COUNT_W'(1);
      end
      if (cmd.mem_read) begin
         rd_count_ff <= count_mem[idx_ff];
         rd_tag_ff   <= tag_mem[idx_ff];
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.kind    = out_kind_ff;
   assign rsp_ch.slot    = out_slot_ff;
   assign rsp_ch.tag_out = out_tag_ff;
   assign rsp_ch.last    = out_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!out_valid_ff || rsp_ch.ready))
      else $error("result loaded over an untaken result");

   a_expmask_in_valid: assert property (@(posedge clock) disable iff (reset)
      (expmask_ff & ~valid_ff) == '0)
      else $error("expiry mask names a free slot");

   a_arm_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.arm_write |-> !valid_ff[idx_ff])
      else $error("arm overwrote a busy slot");

   a_emit_in_mask: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_emit |-> (expmask_ff[idx_ff] && (item_mode_ff == MODE_TICK)))
      else $error("expiry reported for a slot outside the tick snapshot");

endmodule
